// File: hw/rtl/dtl_pkg.sv
package dtl_pkg;

    // Texel store geometry.
    localparam int STORE_TEXELS = 65536;
    localparam int STORE_AW     = $clog2(STORE_TEXELS);
    localparam int COLOR_W      = 24;

    // Angle precision used for the texel index.
    localparam int ANGLE_BITS = 16;
    localparam int QW         = ANGLE_BITS + 1;

    // Image size registers.
    localparam int SIZE_W   = 9;
    localparam int IDX_W    = 8;
    localparam int MAX_SIZE = 256;

    // CORDIC datapath.
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int CW           = 27;
    localparam int ACC_W        = 34;
    localparam logic signed [ACC_W-1:0] HALF_TURN = 34'sh0_8000_0000;

    // Square root datapath.
    localparam int SQ_W = 48;

    // Opcodes.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Register byte offsets (bit 2 selects the register).
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [15:0]        texel_address;
        logic [COLOR_W-1:0] texel_color;
        logic               zero;
    } t_item;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_angle(input logic [STEP_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    // A size register of zero acts as one, anything above the maximum as the maximum.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_SIZE)) begin
            r = SIZE_W'(MAX_SIZE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/dtl_if.sv
interface dtl_item_if;
    import dtl_pkg::*;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        texel_address;
    logic [COLOR_W-1:0] texel_color;
    modport source (output valid, opcode, dir_x, dir_y, dir_z, texel_address, texel_color,
                    input ready);
    modport sink (input valid, opcode, dir_x, dir_y, dir_z, texel_address, texel_color,
                  output ready);
endinterface

interface dtl_result_if;
    import dtl_pkg::*;
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   column;
    logic [IDX_W-1:0]   row;
    logic [COLOR_W-1:0] color;
    logic               zero_direction;
    modport source (output valid, column, row, color, zero_direction, input ready);
    modport sink (input valid, column, row, color, zero_direction, output ready);
endinterface

// File: hw/rtl/dtl_ram.sv
module dtl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/dtl_front.sv
module dtl_front
    import dtl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dtl_item_if.sink    i_item,
    output t_item       o_q_item,
    output logic        o_q_valid,
    input  logic        i_q_pop
);
    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_item      n_item;

    assign i_item.ready = (r_cnt != 2'd2);
    assign push         = i_item.valid && i_item.ready;

    // Classify on entry: zero directions take a short path in the back end.
    always_comb begin
        n_item.opcode        = i_item.opcode;
        n_item.dir_x         = i_item.dir_x;
        n_item.dir_y         = i_item.dir_y;
        n_item.dir_z         = i_item.dir_z;
        n_item.texel_address = i_item.texel_address;
        n_item.texel_color   = i_item.texel_color;
        n_item.zero          = (i_item.dir_x == '0) && (i_item.dir_y == '0) &&
                               (i_item.dir_z == '0);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= n_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    assign o_q_item  = r_mem[r_rp];
    assign o_q_valid = (r_cnt != 2'd0);
endmodule

// File: hw/rtl/dtl_back.sv
module dtl_back
    import dtl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_item             i_q_item,
    input  logic              i_q_valid,
    output logic              o_q_pop,
    input  logic [SIZE_W-1:0] i_width,
    input  logic [SIZE_W-1:0] i_height,
    dtl_result_if.source      o_result
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROT   = 4'd1;
    localparam logic [3:0] S_LOADT = 4'd2;
    localparam logic [3:0] S_ROTT  = 4'd3;
    localparam logic [3:0] S_ANG   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_CLAMP = 4'd6;
    localparam logic [3:0] S_ADDR  = 4'd7;
    localparam logic [3:0] S_READ  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]               r_state, n_state;
    logic [STEP_W-1:0]        r_cnt, n_cnt;
    logic signed [CW-1:0]     r_a, n_a, r_b, n_b;
    logic signed [ACC_W-1:0]  r_acc, n_acc, r_phi, n_phi;
    logic signed [15:0]       r_y, n_y;
    logic [SQ_W-1:0]          r_sq_n, n_sq_n, r_sq_res, n_sq_res;
    logic [32:0]              r_u, n_u, r_v, n_v;
    logic [QW+SIZE_W-1:0]     r_pu, n_pu, r_pv, n_pv;
    logic [IDX_W-1:0]         r_col, n_col, r_row, n_row;
    logic [STORE_AW-1:0]      r_addr, n_addr;
    logic                     r_addr_ok, n_addr_ok;
    logic                     r_zero, n_zero;
    logic                     r_ov, n_ov;
    logic [IDX_W-1:0]         r_ocol, n_ocol, r_orow, n_orow;
    logic [COLOR_W-1:0]       r_ocolor, n_ocolor;
    logic                     r_ozero, n_ozero;

    // CORDIC step and square root step.
    logic [CW-1:0]            b_mag, b_sh;
    logic signed [CW-1:0]     da, db;
    logic signed [ACC_W-1:0]  ang;
    logic [SQ_W-1:0]          sq_bit, sq_sum;
    logic signed [CW-1:0]     st_a, st_b;
    logic signed [ACC_W-1:0]  st_acc;
    logic [SQ_W-1:0]          st_sq_n, st_sq_res;

    // Load helpers.
    logic signed [CW-1:0]     ld_a0, ld_b0, ld_a, ld_b;
    logic signed [ACC_W-1:0]  ld_acc;
    logic signed [31:0]       xx, zz;
    logic [31:0]              r2;
    logic signed [ACC_W-1:0]  th;
    logic [SIZE_W:0]          idx_u, idx_v;
    logic [SIZE_W-1:0]        lim_u, lim_v;
    logic [IDX_W+SIZE_W:0]    addr_full;

    logic                     out_free;
    logic                     ram_we, ram_re;
    logic [STORE_AW-1:0]      ram_waddr;
    logic [COLOR_W-1:0]       ram_rdata;

    assign out_free = !r_ov || o_result.ready;

    always_comb begin
        b_mag = r_b[CW-1] ? CW'(-r_b) : CW'(r_b);
        b_sh  = b_mag >> r_cnt;
        da    = r_b[CW-1] ? -$signed(b_sh) : $signed(b_sh);
        db    = r_a >>> r_cnt;
        ang   = $signed({2'b00, atan_angle(r_cnt)});
        st_a  = r_a;
        st_b  = r_b;
        st_acc = r_acc;
        if (r_b > 0) begin
            st_a   = r_a + da;
            st_b   = r_b - db;
            st_acc = r_acc + ang;
        end else if (r_b < 0) begin
            st_a   = r_a - da;
            st_b   = r_b + db;
            st_acc = r_acc - ang;
        end

        sq_bit  = SQ_W'(1) << (6'(SQ_W - 2) - {r_cnt, 1'b0});
        sq_sum  = r_sq_res + sq_bit;
        if (r_sq_n >= sq_sum) begin
            st_sq_n   = r_sq_n - sq_sum;
            st_sq_res = (r_sq_res >> 1) + sq_bit;
        end else begin
            st_sq_n   = r_sq_n;
            st_sq_res = r_sq_res >> 1;
        end
    end

    // Operand load: a negative first operand is turned by a half turn first.
    always_comb begin
        if (r_state == S_IDLE) begin
            ld_a0 = $signed({{(CW-24){i_q_item.dir_x[15]}}, i_q_item.dir_x, 8'd0});
            ld_b0 = $signed({{(CW-24){i_q_item.dir_z[15]}}, i_q_item.dir_z, 8'd0});
        end else begin
            ld_a0 = $signed({{(CW-24){r_y[15]}}, r_y, 8'd0});
            ld_b0 = $signed({{(CW-24){1'b0}}, r_sq_res[23:0]});
        end
        if (ld_a0 < 0) begin
            ld_acc = (ld_b0 >= 0) ? HALF_TURN : -HALF_TURN;
            ld_a   = -ld_a0;
            ld_b   = -ld_b0;
        end else begin
            ld_acc = '0;
            ld_a   = ld_a0;
            ld_b   = ld_b0;
        end
        xx = i_q_item.dir_x * i_q_item.dir_x;
        zz = i_q_item.dir_z * i_q_item.dir_z;
        r2 = 32'(xx) + 32'(zz);
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_a       = r_a;
        n_b       = r_b;
        n_acc     = r_acc;
        n_phi     = r_phi;
        n_y       = r_y;
        n_sq_n    = r_sq_n;
        n_sq_res  = r_sq_res;
        n_u       = r_u;
        n_v       = r_v;
        n_pu      = r_pu;
        n_pv      = r_pv;
        n_col     = r_col;
        n_row     = r_row;
        n_addr    = r_addr;
        n_addr_ok = r_addr_ok;
        n_zero    = r_zero;
        n_ov      = r_ov && !o_result.ready;
        n_ocol    = r_ocol;
        n_orow    = r_orow;
        n_ocolor  = r_ocolor;
        n_ozero   = r_ozero;
        o_q_pop   = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = i_q_item.texel_address[STORE_AW-1:0];
        th        = '0;
        idx_u     = '0;
        idx_v     = '0;
        lim_u     = i_width - SIZE_W'(1);
        lim_v     = i_height - SIZE_W'(1);
        addr_full = '0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.opcode == OP_WRITE) begin
                        ram_we = (32'(i_q_item.texel_address) < STORE_TEXELS);
                    end else if (i_q_item.zero) begin
                        n_zero    = 1'b1;
                        n_col     = '0;
                        n_row     = '0;
                        n_addr    = '0;
                        n_addr_ok = 1'b1;
                        n_state   = S_READ;
                    end else begin
                        n_zero   = 1'b0;
                        n_a      = ld_a;
                        n_b      = ld_b;
                        n_acc    = ld_acc;
                        n_y      = i_q_item.dir_y;
                        n_sq_n   = {r2, 16'd0};
                        n_sq_res = '0;
                        n_cnt    = '0;
                        n_state  = S_ROT;
                    end
                end
            end
            S_ROT: begin
                n_a      = st_a;
                n_b      = st_b;
                n_acc    = st_acc;
                n_sq_n   = st_sq_n;
                n_sq_res = st_sq_res;
                n_cnt    = r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_LOADT;
                end
            end
            S_LOADT: begin
                if (r_acc > HALF_TURN) begin
                    n_phi = HALF_TURN;
                end else if (r_acc < -HALF_TURN) begin
                    n_phi = -HALF_TURN;
                end else begin
                    n_phi = r_acc;
                end
                n_a     = ld_a;
                n_b     = ld_b;
                n_acc   = ld_acc;
                n_state = S_ROTT;
            end
            S_ROTT: begin
                n_a   = st_a;
                n_b   = st_b;
                n_acc = st_acc;
                n_cnt = r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_ANG;
                end
            end
            S_ANG: begin
                if (r_acc < 0) begin
                    th = '0;
                end else if (r_acc > HALF_TURN) begin
                    th = HALF_TURN;
                end else begin
                    th = r_acc;
                end
                n_u     = 33'(r_phi + HALF_TURN);
                n_v     = {th[31:0], 1'b0};
                n_state = S_MUL;
            end
            S_MUL: begin
                n_pu    = r_u[32 -: QW] * i_width;
                n_pv    = r_v[32 -: QW] * i_height;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                idx_u = r_pu[QW+SIZE_W-1 -: (SIZE_W+1)];
                idx_v = r_pv[QW+SIZE_W-1 -: (SIZE_W+1)];
                n_col = (idx_u > {1'b0, lim_u}) ? lim_u[IDX_W-1:0] : idx_u[IDX_W-1:0];
                n_row = (idx_v > {1'b0, lim_v}) ? lim_v[IDX_W-1:0] : idx_v[IDX_W-1:0];
                n_state = S_ADDR;
            end
            S_ADDR: begin
                addr_full = (IDX_W+SIZE_W+1)'(r_row * i_width) +
                            (IDX_W+SIZE_W+1)'(r_col);
                n_addr    = addr_full[STORE_AW-1:0];
                n_addr_ok = (32'(addr_full) < STORE_TEXELS);
                n_state   = S_READ;
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_ocol   = r_col;
                    n_orow   = r_row;
                    n_ocolor = r_addr_ok ? ram_rdata : '0;
                    n_ozero  = r_zero;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_a       <= n_a;
        r_b       <= n_b;
        r_acc     <= n_acc;
        r_phi     <= n_phi;
        r_y       <= n_y;
        r_sq_n    <= n_sq_n;
        r_sq_res  <= n_sq_res;
        r_u       <= n_u;
        r_v       <= n_v;
        r_pu      <= n_pu;
        r_pv      <= n_pv;
        r_col     <= n_col;
        r_row     <= n_row;
        r_addr    <= n_addr;
        r_addr_ok <= n_addr_ok;
        r_zero    <= n_zero;
        r_ocol    <= n_ocol;
        r_orow    <= n_orow;
        r_ocolor  <= n_ocolor;
        r_ozero   <= n_ozero;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    dtl_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (STORE_TEXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_q_item.texel_color),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign o_result.valid          = r_ov;
    assign o_result.column         = r_ocol;
    assign o_result.row            = r_orow;
    assign o_result.color          = r_ocolor;
    assign o_result.zero_direction = r_ozero;
endmodule

// File: hw/rtl/direction_to_latlong_texel.sv
// Equirectangular environment lookup. Write transactions (opcode 0) store one 24-bit
// texel and produce no result; lookup transactions (opcode 1) turn a ray direction
// into a longitude atan2(z, x) and a polar angle atan2(sqrt(x^2 + z^2), y), map them
// to a clamped column and row of the image size set in the two registers, and return
// the coordinates with the stored color. A write is stored from the idle state without leaving it.
// A lookup leaves the input queue for one 24-step CORDIC pass for longitude with the
// square root running beside it, a second 24-step CORDIC pass for the polar angle,
// then the index multiplies, the address and one registered read of the texel store.
// A zero direction skips the angle work and returns texel 0 with zero_direction set.
// Sustained lookup rate is set by the shared CORDIC unit. A two-entry queue accepts
// transactions while the back end works, and the output register lets the next
// lookup proceed while a result waits. Texels never written read back undefined.
// Registers sit at byte offsets 0 (image_width) and 4 (image_height); only address
// bit 2 is decoded.
module direction_to_latlong_texel
    import dtl_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    dtl_item_if.sink      i_item,
    dtl_result_if.source  o_result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    logic [SIZE_W-1:0] r_image_width;
    logic [SIZE_W-1:0] r_image_height;
    logic              cfg_wr;
    t_item             q_item;
    logic              q_valid;
    logic              q_pop;

    // Register write happens in the access phase; the port never waits.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= SIZE_W'(MAX_SIZE);
            r_image_height <= SIZE_W'(MAX_SIZE);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) begin
                r_image_width <= pwdata[SIZE_W-1:0];
            end else begin
                r_image_height <= pwdata[SIZE_W-1:0];
            end
        end
    end

    // Reads return the raw register value; the offset bits below bit 2 are ignored.
    assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(r_image_height) : 32'(r_image_width);

    // Front end: takes transactions and flags zero directions into a short queue.
    dtl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .o_q_item  (q_item),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop)
    );

    // Back end: texel store, angle computation and result register. Sizes of zero
    // or above the maximum are folded here so the datapath sees a legal range.
    dtl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_item  (q_item),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_width   (eff_size(r_image_width)),
        .i_height  (eff_size(r_image_height)),
        .o_result  (o_result)
    );
endmodule

// File: hw/rtl/dtl_checker.sv
module dtl_checker
    import dtl_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [IDX_W-1:0]   i_column,
    input logic [IDX_W-1:0]   i_row,
    input logic [COLOR_W-1:0] i_color,
    input logic               i_zero,
    input logic               i_pready
);
    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_column) &&
        $stable(i_row) && $stable(i_color) && $stable(i_zero))
        else $error("result changed while stalled");

    // A zero direction always maps to texel 0.
    a_zero_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_zero |-> i_column == '0 && i_row == '0)
        else $error("zero direction with nonzero coordinates");

    // No result directly after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) i_pready)
        else $error("pready low");
endmodule

bind direction_to_latlong_texel dtl_checker u_dtl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_column    (o_result.column),
    .i_row       (o_result.row),
    .i_color     (o_result.color),
    .i_zero      (o_result.zero_direction),
    .i_pready    (pready)
);
